@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mclp_pkg.sv @@
package mclp_pkg;

  localparam int MAX_LINE = 63;
  localparam int LEN_W = $clog2(MAX_LINE + 1);
  localparam int NAME_LEN = 4;

  localparam logic [7:0] NEWLINE = 8'h0A;
  localparam logic [7:0] SPACE = 8'h20;
  localparam logic [7:0] NUL = 8'h00;
  localparam logic [7:0] PLUS = 8'h2B;
  localparam logic [7:0] MINUS = 8'h2D;
  localparam logic [7:0] ZERO = 8'h30;

  typedef enum logic [1:0] {
    TOK_NAME  = 2'd0,
    TOK_TURN  = 2'd1,
    TOK_SPEED = 2'd2,
    TOK_REST  = 2'd3
  } tok_t;

  typedef enum logic [1:0] {
    PH_WAIT   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [LEN_W-1:0] line_length;
    tok_t             tok;
    logic [2:0]       name_pos;
    logic             name_ok;
    phase_t           phase;
    logic             negative;
    logic [7:0]       turn_value;
    logic [7:0]       speed_value;
    logic             nul_seen;
  } line_state_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] turn;
    logic [7:0] speed;
  } result_t;

  typedef struct packed {
    phase_t     phase;
    logic       negative;
    logic [7:0] acc;
  } num_t;

  function automatic line_state_t clear_line();
    line_state_t s;
    s.line_length = '0;
    s.tok         = TOK_NAME;
    s.name_pos    = '0;
    s.name_ok     = 1'b1;
    s.phase       = PH_WAIT;
    s.negative    = 1'b0;
    s.turn_value  = '0;
    s.speed_value = '0;
    s.nul_seen    = 1'b0;
    return s;
  endfunction

  function automatic logic [7:0] name_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = 8'h6D;
      2'd1:    c = 8'h6F;
      2'd2:    c = 8'h76;
      default: c = 8'h65;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b inside {[8'h41:8'h5A]}) r = b + 8'd32;
    return r;
  endfunction

  // One byte of an atoi style number.
  function automatic num_t num_step(input num_t cur, input logic [7:0] b);
    num_t       n;
    logic       digit;
    logic       take;
    logic [7:0] d;
    logic [7:0] t;
    n     = cur;
    digit = b inside {[8'h30:8'h39]};
    take  = 1'b0;
    case (cur.phase)
      PH_WAIT: begin
        if (b inside {8'h09, 8'h0B, 8'h0C, 8'h0D}) begin
          take = 1'b0;
        end else if (b == PLUS) begin
          n.phase = PH_DIGITS;
        end else if (b == MINUS) begin
          n.phase    = PH_DIGITS;
          n.negative = 1'b1;
        end else if (!digit) begin
          n.phase = PH_DONE;
        end else begin
          n.phase = PH_DIGITS;
          take    = 1'b1;
        end
      end
      PH_DIGITS: begin
        if (!digit) n.phase = PH_DONE;
        else take = 1'b1;
      end
      default: take = 1'b0;
    endcase
    d = b - ZERO;
    t = (cur.acc << 3) + (cur.acc << 1);
    if (take) n.acc = n.negative ? (t - d) : (t + d);
    return n;
  endfunction

endpackage

@@ rtl/mclp_parse.sv @@
`include "assert_macros.svh"

module mclp_parse (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  input  logic [7:0]           rx_byte,
  output mclp_pkg::result_t    res
);

  mclp_pkg::line_state_t cur;
  mclp_pkg::line_state_t cur_next;
  mclp_pkg::num_t        num_in;
  mclp_pkg::num_t        num_out;

  always_comb begin
    num_in.phase    = cur.phase;
    num_in.negative = cur.negative;
    num_in.acc      = (cur.tok == mclp_pkg::TOK_TURN) ? cur.turn_value : cur.speed_value;
    num_out         = mclp_pkg::num_step(num_in, rx_byte);
  end

  always_comb begin
    cur_next  = cur;
    res.hit   = 1'b0;
    res.turn  = cur.turn_value;
    res.speed = cur.speed_value;
    if (in_fire) begin
      if (rx_byte == mclp_pkg::NEWLINE) begin
        res.hit  = cur.name_ok && (cur.name_pos == 3'(mclp_pkg::NAME_LEN));
        cur_next = mclp_pkg::clear_line();
      end else begin
        if (cur.line_length >= mclp_pkg::LEN_W'(mclp_pkg::MAX_LINE)) begin
          cur_next = mclp_pkg::clear_line();
        end else begin
          cur_next.line_length = cur.line_length + 1'b1;
          if (!cur.nul_seen) begin
            if (rx_byte == mclp_pkg::NUL) begin
              cur_next.nul_seen = 1'b1;
            end else if (rx_byte == mclp_pkg::SPACE) begin
              if (cur.tok == mclp_pkg::TOK_NAME &&
                  cur.name_pos != 3'(mclp_pkg::NAME_LEN)) cur_next.name_ok = 1'b0;
              if (cur.tok != mclp_pkg::TOK_REST)
                cur_next.tok = mclp_pkg::tok_t'(2'(cur.tok) + 2'd1);
              cur_next.phase    = mclp_pkg::PH_WAIT;
              cur_next.negative = 1'b0;
            end else begin
              case (cur.tok)
                mclp_pkg::TOK_NAME: begin
                  if (cur.name_pos < 3'(mclp_pkg::NAME_LEN) &&
                      mclp_pkg::to_lower(rx_byte) == mclp_pkg::name_char(cur.name_pos[1:0]))
                    cur_next.name_pos = cur.name_pos + 3'd1;
                  else
                    cur_next.name_ok = 1'b0;
                end
                mclp_pkg::TOK_TURN: begin
                  cur_next.phase      = num_out.phase;
                  cur_next.negative   = num_out.negative;
                  cur_next.turn_value = num_out.acc;
                end
                mclp_pkg::TOK_SPEED: begin
                  cur_next.phase       = num_out.phase;
                  cur_next.negative    = num_out.negative;
                  cur_next.speed_value = num_out.acc;
                end
                default: cur_next.tok = cur.tok;
              endcase
            end
          end
        end
        // overflowing byte opens a fresh line: parse it from the cleared state
        if (cur.line_length >= mclp_pkg::LEN_W'(mclp_pkg::MAX_LINE)) begin
          cur_next.line_length = mclp_pkg::LEN_W'(1);
          if (rx_byte == mclp_pkg::NUL) begin
            cur_next.nul_seen = 1'b1;
          end else if (rx_byte == mclp_pkg::SPACE) begin
            cur_next.name_ok = 1'b0;
            cur_next.tok     = mclp_pkg::TOK_TURN;
          end else if (mclp_pkg::to_lower(rx_byte) == mclp_pkg::name_char(2'd0)) begin
            cur_next.name_pos = 3'd1;
          end else begin
            cur_next.name_ok = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= mclp_pkg::clear_line();
    end else begin
      cur <= cur_next;
    end
  end

  `ASSERT_ALWAYS(a_len_bound, clk, rst, cur.line_length <= mclp_pkg::LEN_W'(mclp_pkg::MAX_LINE), "line length past limit")
  `ASSERT_ALWAYS(a_pos_bound, clk, rst, cur.name_pos <= 3'(mclp_pkg::NAME_LEN), "name position past word")
  `ASSERT_NEXT(a_nl_clear, clk, rst, in_fire && rx_byte == mclp_pkg::NEWLINE, cur.line_length == '0 && cur.name_ok, "newline did not clear line")

endmodule

@@ rtl/mclp_out.sv @@
`include "assert_macros.svh"

module mclp_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  mclp_pkg::result_t res,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [7:0]        turn,
  output logic [7:0]        speed
);

  logic out_valid_next;

  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && !out_stall) out_valid_next = 1'b0;
    if (load) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      turn  <= res.turn;
      speed <= res.speed;
    end
  end

  `ASSERT_NEXT(a_load_shows, clk, rst, load, out_valid && turn == $past(res.turn) && speed == $past(res.speed), "loaded result not presented")

endmodule

@@ rtl/move_command_line_parser.sv @@
// A newline beat that closes a "move" line registers its result, shown on out_valid in the cycle after.
// Throughput: one rx_byte beat per cycle; in_stall rises only while a result
// sits in the output register and the sink stalls.
// Reset (rst, synchronous, active high) clears the line state and empties the
// output register; no clearing pass.
module move_command_line_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [7:0] turn,
  output logic signed [7:0] speed
);

  logic              in_fire;
  mclp_pkg::result_t res;
  logic [7:0]        turn_q;
  logic [7:0]        speed_q;

  assign in_stall = out_valid && out_stall;
  assign in_fire  = in_valid && !in_stall;

  mclp_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_fire),
    .rx_byte (rx_byte),
    .res     (res)
  );

  mclp_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res.hit),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .turn      (turn_q),
    .speed     (speed_q)
  );

  assign turn  = signed'(turn_q);
  assign speed = signed'(speed_q);

endmodule
